// File: rtl/bfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfd_pkg: shared types and constants of the box filter downsampler
// Field widths, register indexes, reset values, the reciprocal table used
// by the divide by factor squared, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package bfd_pkg;

    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int SUM_W      = 16;
    localparam int FACTOR_W   = 5;
    localparam int OWIDTH_W   = 11;
    localparam int OHEIGHT_W  = 13;
    localparam int ROW_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int DIV_W      = 9;
    localparam int RECIP_W    = 25;
    localparam int RECIP_SH   = 24;
    localparam int PROD_W     = SUM_W + RECIP_W;

    localparam int DEF_MAX_OUT_WIDTH = 1024;
    localparam int DEF_MAX_FACTOR    = 16;
    localparam int MAX_OUT_HEIGHT    = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_FACTOR     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 2'd2;

    localparam logic [FACTOR_W-1:0]  RST_FACTOR     = 5'd1;
    localparam logic [OWIDTH_W-1:0]  RST_OUT_WIDTH  = 11'd640;
    localparam logic [OHEIGHT_W-1:0] RST_OUT_HEIGHT = 13'd480;

    // floor(2^24 / (f*f)) for f = 1..16; entry 0 is never selected
    localparam logic [RECIP_W-1:0] RECIP [0:16] = '{
        25'd0,
        25'd16777216, 25'd4194304, 25'd1864135, 25'd1048576,
        25'd671088,   25'd466033,  25'd342392,  25'd262144,
        25'd207126,   25'd167772,  25'd138654,  25'd116508,
        25'd99273,    25'd85598,   25'd74565,   25'd65536
    };

    typedef struct packed {
        logic take;   // capture pixel, read the column sum, advance position
        logic acc;    // add pixel to the column sum and write it back
        logic mul;    // multiply block sums by the reciprocal
        logic load;   // correct the quotient and load the output register
    } bfd_cmd_t;

    typedef struct packed {
        logic blk_last;  // request in flight closes a block
        logic out_free;  // output register can take a new result
    } bfd_sts_t;

endpackage
`default_nettype wire

// File: rtl/bfd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfd_ctrl: sequencing of the box filter downsampler
// Steps one request through read and accumulate, then multiply and correct when it closes a block.
// ----------------------------------------------------------------------------
module bfd_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire bfd_pkg::bfd_sts_t sts,
    output bfd_pkg::bfd_cmd_t      cmd
);
    import bfd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ACC  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
                if (s_valid) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = sts.blk_last ? ST_MUL : ST_IDLE;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                // hold until the previous result has been taken
                cmd.load = sts.out_free;
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/bfd_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfd_dp: datapath of the box filter downsampler
// Configuration registers, frame position counters, the line store of
// per-column channel sums, the reciprocal divide and the output register.
// ----------------------------------------------------------------------------
module bfd_dp #(
    parameter int MAX_OUT_WIDTH = bfd_pkg::DEF_MAX_OUT_WIDTH,
    parameter int MAX_FACTOR    = bfd_pkg::DEF_MAX_FACTOR
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [bfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bfd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic [bfd_pkg::PIX_W-1:0]       s_pixel,
    input  wire bfd_pkg::bfd_cmd_t               cmd,
    output bfd_pkg::bfd_sts_t                    sts,
    output logic [bfd_pkg::PIX_W-1:0]            m_avg_pixel,
    output logic                                 m_row_end,
    output logic                                 m_valid,
    input  wire logic                            m_ready
);
    import bfd_pkg::*;

    localparam int COL_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
    localparam int PH_W  = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
    localparam int MEM_W = NUM_CH * SUM_W;

    // configuration
    logic [FACTOR_W-1:0]  factor_reg;
    logic [OWIDTH_W-1:0]  out_width_reg;
    logic [OHEIGHT_W-1:0] out_height_reg;
    logic [FACTOR_W-1:0]  f_eff;
    logic [OHEIGHT_W-1:0] w_eff;
    logic [OHEIGHT_W-1:0] h_eff;

    // position
    logic [PH_W-1:0]  phase_reg;
    logic [PH_W-1:0]  sub_row_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic             phase_end;
    logic             sub_row_end;
    logic             col_end;
    logic             row_wrap;

    // request in flight
    logic [PIX_W-1:0] pix_reg;
    logic [COL_W-1:0] addr_reg;
    logic             first_reg;
    logic             last_reg;
    logic             rowend_reg;

    logic [MEM_W-1:0] mem [MAX_OUT_WIDTH];
    logic [MEM_W-1:0] rd_reg;
    logic [MEM_W-1:0] sum_next;
    logic [MEM_W-1:0] sum_reg;

    logic [DIV_W-1:0]   d_reg;
    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  prod_reg [NUM_CH];
    logic [PIX_W-1:0]   quo;

    logic [PIX_W-1:0] out_pix_reg;
    logic             out_rowend_reg;
    logic             out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_reg     <= RST_FACTOR;
            out_width_reg  <= RST_OUT_WIDTH;
            out_height_reg <= RST_OUT_HEIGHT;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FACTOR:     factor_reg     <= cfg_wdata[FACTOR_W-1:0];
                REG_OUT_WIDTH:  out_width_reg  <= cfg_wdata[OWIDTH_W-1:0];
                REG_OUT_HEIGHT: out_height_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // clamp configuration into its working range
    always_comb begin
        if (factor_reg == '0) begin
            f_eff = 5'd1;
        end else if (factor_reg > FACTOR_W'(MAX_FACTOR)) begin
            f_eff = FACTOR_W'(MAX_FACTOR);
        end else begin
            f_eff = factor_reg;
        end
        if (out_width_reg == '0) begin
            w_eff = 13'd1;
        end else if (OHEIGHT_W'(out_width_reg) > OHEIGHT_W'(MAX_OUT_WIDTH)) begin
            w_eff = OHEIGHT_W'(MAX_OUT_WIDTH);
        end else begin
            w_eff = OHEIGHT_W'(out_width_reg);
        end
        if (out_height_reg == '0) begin
            h_eff = 13'd1;
        end else if (out_height_reg > OHEIGHT_W'(MAX_OUT_HEIGHT)) begin
            h_eff = OHEIGHT_W'(MAX_OUT_HEIGHT);
        end else begin
            h_eff = out_height_reg;
        end
    end

    assign phase_end   = (FACTOR_W'(phase_reg) == f_eff - 5'd1);
    assign sub_row_end = (FACTOR_W'(sub_row_reg) == f_eff - 5'd1);
    assign col_end     = (OHEIGHT_W'(col_reg) == w_eff - 13'd1);
    assign row_wrap    = (OHEIGHT_W'(out_row_reg) + 13'd1 >= h_eff);

    // any register write returns the position to the start of a frame
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            phase_reg   <= '0;
            sub_row_reg <= '0;
            col_reg     <= '0;
            out_row_reg <= '0;
        end else if (cmd.take) begin
            if (!phase_end) begin
                phase_reg <= phase_reg + 1'b1;
            end else begin
                phase_reg <= '0;
                if (!col_end) begin
                    col_reg <= col_reg + 1'b1;
                end else begin
                    col_reg <= '0;
                    if (!sub_row_end) begin
                        sub_row_reg <= sub_row_reg + 1'b1;
                    end else begin
                        sub_row_reg <= '0;
                        out_row_reg <= row_wrap ? '0 : out_row_reg + 12'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= 1'b0;
        end else if (cmd.take) begin
            last_reg <= sub_row_end && phase_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            pix_reg    <= s_pixel;
            addr_reg   <= col_reg;
            first_reg  <= (sub_row_reg == '0) && (phase_reg == '0);
            rowend_reg <= col_end;
            rd_reg     <= mem[col_reg];
        end
    end

    // the first pixel of a block overwrites the stale column sum
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            if (first_reg) begin
                sum_next[c*SUM_W +: SUM_W] = SUM_W'(pix_reg[c*CH_W +: CH_W]);
            end else begin
                sum_next[c*SUM_W +: SUM_W] = rd_reg[c*SUM_W +: SUM_W]
                                           + SUM_W'(pix_reg[c*CH_W +: CH_W]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc) begin
            mem[addr_reg] <= sum_next;
            sum_reg       <= sum_next;
        end
    end

    assign recip = RECIP[f_eff];

    always_ff @(posedge aclk) begin
        d_reg <= DIV_W'(f_eff * f_eff);
        if (cmd.mul) begin
            for (int c = 0; c < NUM_CH; c++) begin
                prod_reg[c] <= PROD_W'(sum_reg[c*SUM_W +: SUM_W]) * PROD_W'(recip);
            end
        end
    end

    // estimate is exact or one low; fix it with a single compare
    always_comb begin
        logic [CH_W-1:0]  q_est;
        logic [SUM_W:0]   qd;
        logic [SUM_W:0]   rem;
        for (int c = 0; c < NUM_CH; c++) begin
            q_est = prod_reg[c][RECIP_SH +: CH_W];
            qd    = (SUM_W+1)'(q_est) * (SUM_W+1)'(d_reg);
            rem   = (SUM_W+1)'(sum_reg[c*SUM_W +: SUM_W]) - qd;
            quo[c*CH_W +: CH_W] = (rem >= (SUM_W+1)'(d_reg)) ? q_est + 8'd1 : q_est;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_pix_reg    <= quo;
            out_rowend_reg <= rowend_reg;
        end
    end

    assign m_avg_pixel  = out_pix_reg;
    assign m_row_end    = out_rowend_reg;
    assign m_valid      = out_valid_reg;
    assign sts.out_free = !out_valid_reg || m_ready;
    assign sts.blk_last = last_reg;

endmodule
`default_nettype wire

// File: rtl/box_filter_downsample_rgb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_filter_downsample_rgb: box filter downsampler for packed RGB pixels
// Averages each factor-by-factor block of a supersampled raster image.
//
//   channel   ports                           direction
//   input     s_valid s_ready s_pixel          in
//   result    m_valid m_ready m_avg_pixel/row  out
//   config    cfg_we cfg_index cfg_wdata       in (write only)
//
// A pixel that does not close a block is read from the line store, then
// added and written back. For a block-closing pixel the reciprocal
// multiply and the quotient correction follow the write back.
// The line store needs no clearing pass; reset clears the control state.
// A pending result in the output register stalls only the final step.
// ----------------------------------------------------------------------------
module box_filter_downsample_rgb #(
    parameter int MAX_OUT_WIDTH = bfd_pkg::DEF_MAX_OUT_WIDTH,
    parameter int MAX_FACTOR    = bfd_pkg::DEF_MAX_FACTOR
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [bfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bfd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [bfd_pkg::PIX_W-1:0]       s_pixel,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [bfd_pkg::PIX_W-1:0]            m_avg_pixel,
    output logic                                 m_row_end
);
    import bfd_pkg::*;

    bfd_cmd_t cmd;
    bfd_sts_t sts;

    bfd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bfd_dp #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
        .MAX_FACTOR    (MAX_FACTOR)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_pixel     (s_pixel),
        .cmd         (cmd),
        .sts         (sts),
        .m_avg_pixel (m_avg_pixel),
        .m_row_end   (m_row_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready)
    );

endmodule
`default_nettype wire

// File: verif/box_filter_downsample_rgb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_downsample_rgb_checker: result checker for the box downsampler
// Watches the config port and both streams. Folds every accepted pixel into
// its own copy of the per-column block sums and queues each block average.
// Compares each accepted result with the oldest queued average.
// ----------------------------------------------------------------------------
module box_filter_downsample_rgb_checker
    import bfd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire logic [PIX_W-1:0]      s_pixel,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire logic [PIX_W-1:0]      m_avg_pixel,
    input  wire logic                  m_row_end,
    output int                         n_errors,
    output int                         n_pending
);

    typedef struct packed {
        logic [SUM_W-1:0] r;
        logic [SUM_W-1:0] g;
        logic [SUM_W-1:0] b;
    } chan_sums_t;

    typedef struct packed {
        logic [PIX_W-1:0] avg_pixel;
        logic             row_end;
    } block_avg_t;

    chan_sums_t          column_sums [0:DEF_MAX_OUT_WIDTH-1];
    int unsigned         src_col;
    int unsigned         band_row;
    int unsigned         frame_row;
    logic [FACTOR_W-1:0] factor_reg;
    logic [OWIDTH_W-1:0] width_reg;
    logic [OHEIGHT_W-1:0] height_reg;
    block_avg_t          pending_avgs [$];

    function automatic int unsigned clamp_reg(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        n_errors++;
    endtask

    // Add one source pixel to its column sum; queue the average on block end.
    task automatic fold_pixel(input logic [PIX_W-1:0] px);
        int unsigned f;
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned ph;
        int unsigned div;
        chan_sums_t  s;
        block_avg_t  res;
        f   = clamp_reg(factor_reg, DEF_MAX_FACTOR);
        w   = clamp_reg(width_reg, DEF_MAX_OUT_WIDTH);
        h   = clamp_reg(height_reg, MAX_OUT_HEIGHT);
        col = src_col / f;
        ph  = src_col % f;
        if (col >= w) col = w - 1;
        s = column_sums[col];
        // first pixel of a block overwrites whatever the column held
        if (band_row == 0 && ph == 0) begin
            s.r = SUM_W'(px[2*CH_W +: CH_W]);
            s.g = SUM_W'(px[CH_W +: CH_W]);
            s.b = SUM_W'(px[0 +: CH_W]);
        end else begin
            s.r = s.r + SUM_W'(px[2*CH_W +: CH_W]);
            s.g = s.g + SUM_W'(px[CH_W +: CH_W]);
            s.b = s.b + SUM_W'(px[0 +: CH_W]);
        end
        column_sums[col] = s;
        if (band_row == f - 1 && ph == f - 1) begin
            div = f * f;
            res.avg_pixel = {CH_W'(s.r / div), CH_W'(s.g / div), CH_W'(s.b / div)};
            res.row_end   = (col == w - 1);
            pending_avgs.push_back(res);
        end
        src_col++;
        if (src_col >= f * w) begin
            src_col = 0;
            band_row++;
            if (band_row >= f) begin
                band_row = 0;
                frame_row++;
                if (frame_row >= h) frame_row = 0;
            end
        end
    endtask

    always @(posedge aclk) begin
        block_avg_t want;
        if (!aresetn) begin
            for (int i = 0; i < DEF_MAX_OUT_WIDTH; i++) column_sums[i] = '0;
            src_col    = 0;
            band_row   = 0;
            frame_row  = 0;
            factor_reg = RST_FACTOR;
            width_reg  = RST_OUT_WIDTH;
            height_reg = RST_OUT_HEIGHT;
            n_errors   = 0;
            pending_avgs.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_FACTOR: begin
                        factor_reg = cfg_wdata[FACTOR_W-1:0];
                    end
                    REG_OUT_WIDTH: begin
                        width_reg = cfg_wdata[OWIDTH_W-1:0];
                    end
                    REG_OUT_HEIGHT: begin
                        height_reg = cfg_wdata[OHEIGHT_W-1:0];
                    end
                    default: begin
                    end
                endcase
                // any write restarts the frame; sums are kept
                src_col   = 0;
                band_row  = 0;
                frame_row = 0;
            end
            if (s_valid && s_ready) fold_pixel(s_pixel);
            if (m_valid && m_ready) begin
                if (pending_avgs.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result %06h row_end %0b",
                                            m_avg_pixel, m_row_end));
                end else begin
                    want = pending_avgs.pop_front();
                    if (m_avg_pixel !== want.avg_pixel)
                        flag_mismatch($sformatf("avg_pixel got %06h want %06h",
                                                m_avg_pixel, want.avg_pixel));
                    if (m_row_end !== want.row_end)
                        flag_mismatch($sformatf("row_end got %0b want %0b",
                                                m_row_end, want.row_end));
                end
            end
        end
        n_pending <= pending_avgs.size();
    end

endmodule

// File: verif/box_filter_downsample_rgb_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_downsample_rgb_tb: stimulus and verdict for the box downsampler
// Streams supersampled pixels under many factor/width/height settings, with
// random gaps and output stalls and one long output hold-off. The checker
// beside the block predicts every average and counts mismatches.
// ----------------------------------------------------------------------------
module box_filter_downsample_rgb_tb;
    import bfd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1600;
    localparam int CALM_ITEMS   = 200;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;

    // index past the register list: only restarts the frame
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic [PIX_W-1:0]      s_pixel   = '0;
    logic                  m_ready   = 1'b0;
    wire                   s_ready;
    wire                   m_valid;
    wire [PIX_W-1:0]       m_avg_pixel;
    wire                   m_row_end;

    int   n_errors;
    int   n_pending;
    int   n_sent    = 0;
    int   cycles    = 0;
    int   calm_from = CYCLE_LIMIT;
    logic calm      = 1'b0;
    logic hold_req  = 1'b0;
    logic rx_hold   = 1'b0;

    box_filter_downsample_rgb dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel     (s_pixel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_avg_pixel (m_avg_pixel),
        .m_row_end   (m_row_end)
    );

    box_filter_downsample_rgb_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel     (s_pixel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_avg_pixel (m_avg_pixel),
        .m_row_end   (m_row_end),
        .n_errors    (n_errors),
        .n_pending   (n_pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // output side: random stall bursts, plus the long hold-off when asked
    initial begin : ready_gen
        int idle_left;
        idle_left = 0;
        forever begin
            @(negedge aclk);
            if (rx_hold || idle_left > 0) begin
                m_ready <= 1'b0;
                if (idle_left > 0) idle_left--;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_ready   <= 1'b0;
                idle_left = $urandom_range(0, 7);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : hold_gen
        wait (hold_req);
        @(negedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        rx_hold <= 1'b0;
    end

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // Offer one pixel, optionally after a gap, and hold it until taken.
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        int gap;
        // stop all idling for the tail of the run
        if (n_sent >= calm_from) calm <= 1'b1;
        gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        n_sent++;
    endtask

    // Drop valid, wait for every average, then let the last pixels retire.
    task automatic settle();
        s_valid <= 1'b0;
        while (n_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Upper data bits beyond the factor and width registers are random and must be ignored.
    task automatic set_config(input logic [FACTOR_W-1:0] f, input logic [OWIDTH_W-1:0] w,
                              input logic [OHEIGHT_W-1:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FACTOR;
        cfg_wdata <= {8'($urandom), f};
        @(negedge aclk);
        cfg_index <= REG_OUT_WIDTH;
        cfg_wdata <= {2'($urandom), w};
        @(negedge aclk);
        cfg_index <= REG_OUT_HEIGHT;
        cfg_wdata <= h;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [FACTOR_W-1:0] f, input logic [OWIDTH_W-1:0] w,
                             input logic [OHEIGHT_W-1:0] h, input int n);
        settle();
        set_config(f, w, h);
        repeat (n) send_pixel(pick_pixel());
    endtask

    initial begin : stimulus
        logic [FACTOR_W-1:0]  f;
        logic [OWIDTH_W-1:0]  w;
        logic [OHEIGHT_W-1:0] h;
        int f_eff;
        int w_eff;
        int blk;
        int n;
        int phase;
        int rand_start;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: factor one, every pixel is its own average
        send_pixel('0);
        send_pixel('1);
        send_pixel(24'h123456);
        send_pixel(24'h80FF01);

        // zero registers act as one: each pixel ends a row and the frame
        run_phase('0, '0, '0, 3);

        // saturated 2x2 blocks, two columns
        settle();
        set_config(FACTOR_W'(2), OWIDTH_W'(2), OHEIGHT_W'(1));
        repeat (8) send_pixel('1);

        // a write to an unused index restarts the block mid-band
        run_phase(FACTOR_W'(2), OWIDTH_W'(1), OHEIGHT_W'(2), 2);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_UNUSED;
        cfg_wdata <= CFG_DATA_W'($urandom);
        @(negedge aclk);
        cfg_we <= 1'b0;
        repeat (4) send_pixel(pick_pixel());

        rand_start = n_sent;
        calm_from  = rand_start + RANDOM_ITEMS - CALM_ITEMS;
        phase      = 0;
        while (n_sent - rand_start < RANDOM_ITEMS) begin
            if (phase == 3) begin
                // factor one fills the output quickly while the receiver holds off
                f = FACTOR_W'(1);
                w = OWIDTH_W'(4);
                h = OHEIGHT_W'(2);
                n = 96;
                hold_req <= 1'b1;
            end else if (phase == 6) begin
                // widest line store: width above the maximum saturates
                f = FACTOR_W'(1);
                w = OWIDTH_W'($urandom_range(DEF_MAX_OUT_WIDTH, 2047));
                h = OHEIGHT_W'($urandom_range(1, 2));
                n = DEF_MAX_OUT_WIDTH + $urandom_range(1, 16);
            end else begin
                case ($urandom_range(0, 19))
                    0:       f = '0;
                    1, 2:    f = FACTOR_W'($urandom_range(5, DEF_MAX_FACTOR));
                    3:       f = FACTOR_W'($urandom_range(DEF_MAX_FACTOR + 1, 31));
                    default: f = FACTOR_W'($urandom_range(1, 4));
                endcase
                f_eff = (f == 0) ? 1 : (f > DEF_MAX_FACTOR) ? DEF_MAX_FACTOR : int'(f);
                if ($urandom_range(0, 9) == 0) w = '0;
                else if (f_eff >= 9) w = OWIDTH_W'(1);
                else if (f_eff >= 5) w = OWIDTH_W'($urandom_range(1, 2));
                else w = OWIDTH_W'($urandom_range(1, 8));
                case ($urandom_range(0, 9))
                    0:       h = '0;
                    1:       h = OHEIGHT_W'($urandom_range(MAX_OUT_HEIGHT + 1, 8191));
                    2:       h = OHEIGHT_W'($urandom_range(4, MAX_OUT_HEIGHT));
                    default: h = OHEIGHT_W'($urandom_range(1, 3));
                endcase
                w_eff = (w == 0) ? 1 : int'(w);
                blk   = f_eff * f_eff * w_eff;
                n     = blk * ((blk > 64) ? 1 : $urandom_range(1, 3))
                        + $urandom_range(0, f_eff * w_eff);
            end
            run_phase(f, w, h, n);
            phase++;
        end

        settle();
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
